// ===== src/bror_pkg.sv =====
// Shared types and constants for the box range overlap query block.
`timescale 1ns / 1ps
package bror_pkg;

  localparam int unsigned NUM_TILES_DEF = 16;
  localparam int unsigned MAX_DIMS_DEF  = 4;

  localparam int unsigned COORD_W  = 64;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned DSLOT_W  = 2;
  localparam int unsigned TILENUM_W = 4;
  localparam int unsigned TILES_W  = 5;
  localparam int unsigned DIMS_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RANGE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TILES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 1'b1;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd2;

  // Tag that travels with one tile through the scan pipeline.
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [TILENUM_W-1:0] tile;
  } bror_tag_t;

endpackage

// ===== src/bror_box_mem.sv =====
// Tile bounding box memory: one row per tile, one lane per dimension, registered read.
`timescale 1ns / 1ps
module bror_box_mem
  import bror_pkg::*;
#(
  parameter int unsigned NUM_TILES = NUM_TILES_DEF,
  parameter int unsigned MAX_DIMS  = MAX_DIMS_DEF,
  localparam int unsigned TileW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1,
  localparam int unsigned DimW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                               clk_i,
  input  logic                               wr_en_i,
  input  logic [TileW-1:0]                   wr_tile_i,
  input  logic [DimW-1:0]                    wr_dim_i,
  input  logic [COORD_W-1:0]                 wr_min_i,
  input  logic [COORD_W-1:0]                 wr_max_i,
  input  logic                               rd_en_i,
  input  logic [TileW-1:0]                   rd_tile_i,
  output logic [MAX_DIMS-1:0][COORD_W-1:0]   rd_min_o,
  output logic [MAX_DIMS-1:0][COORD_W-1:0]   rd_max_o
);

  logic [MAX_DIMS-1:0][COORD_W-1:0] min_mem [NUM_TILES];
  logic [MAX_DIMS-1:0][COORD_W-1:0] max_mem [NUM_TILES];

  // A load writes a single dimension lane of its tile row.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      min_mem[wr_tile_i][wr_dim_i] <= wr_min_i;
      max_mem[wr_tile_i][wr_dim_i] <= wr_max_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_min_o <= min_mem[rd_tile_i];
      rd_max_o <= max_mem[rd_tile_i];
    end
  end

endmodule

// ===== src/bror_classify.sv =====
// Query range registers and the per-dimension overlap and containment compare stage.
`timescale 1ns / 1ps
module bror_classify
  import bror_pkg::*;
#(
  parameter int unsigned MAX_DIMS = MAX_DIMS_DEF,
  localparam int unsigned DimW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_wr_en_i,
  input  logic [DimW-1:0]                  q_wr_dim_i,
  input  logic [COORD_W-1:0]               q_wr_low_i,
  input  logic [COORD_W-1:0]               q_wr_high_i,
  input  logic [MAX_DIMS-1:0]              dim_mask_i,
  input  logic                             adv_i,
  input  bror_tag_t                        tag_i,
  input  logic [MAX_DIMS-1:0][COORD_W-1:0] box_min_i,
  input  logic [MAX_DIMS-1:0][COORD_W-1:0] box_max_i,
  output bror_tag_t                        tag_o,
  output logic                             overlaps_o,
  output logic                             whole_o
);

  logic [COORD_W-1:0]  qlow_q  [MAX_DIMS];
  logic [COORD_W-1:0]  qhigh_q [MAX_DIMS];
  logic [MAX_DIMS-1:0] ov_dim_d, ov_dim_q;
  logic [MAX_DIMS-1:0] wh_dim_d, wh_dim_q;
  bror_tag_t           tag_q;

  always_ff @(posedge clk_i) begin
    if (q_wr_en_i) begin
      qlow_q[q_wr_dim_i]  <= q_wr_low_i;
      qhigh_q[q_wr_dim_i] <= q_wr_high_i;
    end
  end

  // Dimensions past the active count are forced to pass.
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      ov_dim_d[d] = !dim_mask_i[d] ||
                    (($signed(qlow_q[d]) <= $signed(box_max_i[d])) &&
                     ($signed(box_min_i[d]) <= $signed(qhigh_q[d])));
      wh_dim_d[d] = !dim_mask_i[d] ||
                    (($signed(qlow_q[d]) <= $signed(box_min_i[d])) &&
                     ($signed(box_max_i[d]) <= $signed(qhigh_q[d])));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (adv_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ov_dim_q <= ov_dim_d;
      wh_dim_q <= wh_dim_d;
    end
  end

  assign tag_o      = tag_q;
  assign overlaps_o = &ov_dim_q;
  assign whole_o    = &wh_dim_q;

endmodule

// ===== src/box_range_overlap_query.sv =====
// Top level of the box range overlap query block: command decode, scan sequencer, output register.
//
//   port group   direction  handshake                    contents
//   in_*         input      in_valid_i / in_ready_o      opcode, slots, range low/high
//   out_*        output     out_valid_o / out_ready_i    tile number, overlaps, whole, partial, last
//   cfg_*        input      cfg_we_i                     tiles_in_use, dims_in_use
//
// A query reads one tile row per cycle from the box memory, one row for each
// tile in use, while the output register is not stalled; each result then passes
// through the memory read register, the compare register and the output register.
// A stalled output register holds the whole scan pipeline. Reset clears control
// and configuration only; the box and query stores hold garbage until written.
`timescale 1ns / 1ps
module box_range_overlap_query
  import bror_pkg::*;
#(
  parameter int unsigned NUM_TILES = NUM_TILES_DEF,
  parameter int unsigned MAX_DIMS  = MAX_DIMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OPCODE_W-1:0]   opcode_i,
  input  logic [SLOT_W-1:0]     tile_slot_i,
  input  logic [DSLOT_W-1:0]    dim_slot_i,
  input  logic [COORD_W-1:0]    range_low_i,
  input  logic [COORD_W-1:0]    range_high_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TILENUM_W-1:0]  tile_number_o,
  output logic                  overlaps_o,
  output logic                  whole_o,
  output logic                  partial_o,
  output logic                  last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned TileW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  localparam int unsigned DimW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned CntW  = ($clog2(NUM_TILES + 1) > TILES_W) ?
                                  $clog2(NUM_TILES + 1) : TILES_W;
  localparam int unsigned DCntW = ($clog2(MAX_DIMS + 1) > DIMS_W) ?
                                  $clog2(MAX_DIMS + 1) : DIMS_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state_d, state_q;
  logic [TileW-1:0]     idx_d, idx_q;
  logic [TileW-1:0]     last_idx_d, last_idx_q;
  logic [TILES_W-1:0]   tiles_q;
  logic [DIMS_W-1:0]    dims_q;
  logic [CntW-1:0]      tiles_ext, eff_tiles;
  logic [DCntW-1:0]     dims_ext, eff_dims;
  logic [MAX_DIMS-1:0]  dim_mask;
  logic                 accept, adv, issue, tile_ok, dim_ok;
  logic                 box_wr_en, q_wr_en;
  bror_tag_t            tag1_d, tag1_q, tag2;
  logic [MAX_DIMS-1:0][COORD_W-1:0] row_min, row_max;
  logic                 ov2, wh2;
  logic                 out_valid_q;
  logic [TILENUM_W-1:0] out_tile_q;
  logic                 out_ov_q, out_wh_q, out_last_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_q <= '0;
      dims_q  <= DIMS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TILES: tiles_q <= cfg_data_i[TILES_W-1:0];
        CFG_DIMS:  dims_q  <= cfg_data_i[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign tiles_ext = CntW'(tiles_q);
  assign eff_tiles = (tiles_ext > CntW'(NUM_TILES)) ? CntW'(NUM_TILES) : tiles_ext;
  assign dims_ext  = DCntW'(dims_q);
  assign eff_dims  = (dims_ext > DCntW'(MAX_DIMS)) ? DCntW'(MAX_DIMS) : dims_ext;

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      dim_mask[d] = DCntW'(d) < eff_dims;
    end
  end

  // The pipeline moves only when the output register is free or being emptied.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && !tag1_q.valid && !tag2.valid;
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_SCAN) && adv;

  assign tile_ok   = 32'(tile_slot_i) < NUM_TILES;
  assign dim_ok    = 32'(dim_slot_i) < MAX_DIMS;
  assign box_wr_en = accept && (opcode_i == OP_LOAD) && tile_ok && dim_ok;
  assign q_wr_en   = accept && (opcode_i == OP_RANGE) && dim_ok;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (opcode_i == OP_QUERY) && (eff_tiles != '0)) begin
          state_d    = ST_SCAN;
          idx_d      = '0;
          last_idx_d = TileW'(eff_tiles - CntW'(1));
        end
      end
      ST_SCAN: begin
        if (issue) begin
          if (idx_q == last_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + TileW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    last_idx_q <= last_idx_d;
  end

  always_comb begin
    tag1_d.valid = issue;
    tag1_d.last  = idx_q == last_idx_q;
    tag1_d.tile  = TILENUM_W'(idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
    end else if (adv) begin
      tag1_q <= tag1_d;
    end
  end

  bror_box_mem #(
    .NUM_TILES (NUM_TILES),
    .MAX_DIMS  (MAX_DIMS)
  ) u_box_mem (
    .clk_i     (clk_i),
    .wr_en_i   (box_wr_en),
    .wr_tile_i (TileW'(tile_slot_i)),
    .wr_dim_i  (DimW'(dim_slot_i)),
    .wr_min_i  (range_low_i),
    .wr_max_i  (range_high_i),
    .rd_en_i   (adv),
    .rd_tile_i (idx_q),
    .rd_min_o  (row_min),
    .rd_max_o  (row_max)
  );

  bror_classify #(
    .MAX_DIMS (MAX_DIMS)
  ) u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_wr_en_i   (q_wr_en),
    .q_wr_dim_i  (DimW'(dim_slot_i)),
    .q_wr_low_i  (range_low_i),
    .q_wr_high_i (range_high_i),
    .dim_mask_i  (dim_mask),
    .adv_i       (adv),
    .tag_i       (tag1_q),
    .box_min_i   (row_min),
    .box_max_i   (row_max),
    .tag_o       (tag2),
    .overlaps_o  (ov2),
    .whole_o     (wh2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tag2.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_tile_q <= tag2.tile;
      out_ov_q   <= ov2;
      out_wh_q   <= wh2;
      out_last_q <= tag2.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tile_number_o = out_tile_q;
  assign overlaps_o    = out_ov_q;
  assign whole_o       = out_wh_q;
  assign partial_o     = out_ov_q && !out_wh_q;
  assign last_o        = out_last_q;

endmodule

// ===== tb/sv/bror_overlap_checker.sv =====
// Checker for the box range overlap query block: predicts tile verdicts and compares results.
`timescale 1ns / 1ps
module bror_overlap_checker
  import bror_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [OPCODE_W-1:0]   opcode_i,
  input  logic [SLOT_W-1:0]     tile_slot_i,
  input  logic [DSLOT_W-1:0]    dim_slot_i,
  input  logic [COORD_W-1:0]    range_low_i,
  input  logic [COORD_W-1:0]    range_high_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [TILENUM_W-1:0]  tile_number_i,
  input  logic                  overlaps_i,
  input  logic                  whole_i,
  input  logic                  partial_i,
  input  logic                  last_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [TILENUM_W-1:0] tile;
    logic                 overlaps;
    logic                 whole;
    logic                 partial;
    logic                 last;
  } tile_verdict_t;

  logic signed [COORD_W-1:0] box_lo   [NUM_TILES_DEF][MAX_DIMS_DEF];
  logic signed [COORD_W-1:0] box_hi   [NUM_TILES_DEF][MAX_DIMS_DEF];
  logic signed [COORD_W-1:0] query_lo [MAX_DIMS_DEF];
  logic signed [COORD_W-1:0] query_hi [MAX_DIMS_DEF];
  logic [TILES_W-1:0]        tiles_cfg;
  logic [DIMS_W-1:0]         dims_cfg;
  tile_verdict_t             verdicts_due [$];
  tile_verdict_t             want;
  int                        scan_tiles;
  int                        scan_dims;
  logic                      hit;
  logic                      contained;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_cfg = '0;
      dims_cfg = DIMS_RESET;
      verdicts_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TILES: tiles_cfg = cfg_data_i[TILES_W-1:0];
          CFG_DIMS:  dims_cfg = cfg_data_i[DIMS_W-1:0];
          default: ;
        endcase
      end

      // Results are retired before new commands so that a result can never match
      // an expectation created at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result with nothing expected: tile %0d ov %0b wh %0b pa %0b last %0b",
                   $time, tile_number_i, overlaps_i, whole_i, partial_i, last_i);
          fail_count_o++;
        end else begin
          want = verdicts_due.pop_front();
          if (tile_number_i !== want.tile) begin
            $display("%0t: tile_number expected %0d actual %0d", $time, want.tile, tile_number_i);
            fail_count_o++;
          end
          if (overlaps_i !== want.overlaps) begin
            $display("%0t: tile %0d overlaps expected %0b actual %0b",
                     $time, want.tile, want.overlaps, overlaps_i);
            fail_count_o++;
          end
          if (whole_i !== want.whole) begin
            $display("%0t: tile %0d whole expected %0b actual %0b",
                     $time, want.tile, want.whole, whole_i);
            fail_count_o++;
          end
          if (partial_i !== want.partial) begin
            $display("%0t: tile %0d partial expected %0b actual %0b",
                     $time, want.tile, want.partial, partial_i);
            fail_count_o++;
          end
          if (last_i !== want.last) begin
            $display("%0t: tile %0d last expected %0b actual %0b",
                     $time, want.tile, want.last, last_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        case (opcode_i)
          OP_LOAD: begin
            if (tile_slot_i < NUM_TILES_DEF && dim_slot_i < MAX_DIMS_DEF) begin
              box_lo[tile_slot_i][dim_slot_i] = range_low_i;
              box_hi[tile_slot_i][dim_slot_i] = range_high_i;
            end
          end
          OP_RANGE: begin
            if (dim_slot_i < MAX_DIMS_DEF) begin
              query_lo[dim_slot_i] = range_low_i;
              query_hi[dim_slot_i] = range_high_i;
            end
          end
          OP_QUERY: begin
            scan_tiles = (tiles_cfg > NUM_TILES_DEF) ? NUM_TILES_DEF : tiles_cfg;
            scan_dims = (dims_cfg > MAX_DIMS_DEF) ? MAX_DIMS_DEF : dims_cfg;
            for (int t = 0; t < scan_tiles; t++) begin
              hit = 1'b1;
              contained = 1'b1;
              // Bounds are never checked for order, so an inverted box can be whole
              // without overlapping the query.
              for (int d = 0; d < scan_dims; d++) begin
                if (query_lo[d] > box_hi[t][d] || box_lo[t][d] > query_hi[d]) hit = 1'b0;
                if (box_lo[t][d] < query_lo[d] || box_hi[t][d] > query_hi[d]) contained = 1'b0;
              end
              want.tile = t[TILENUM_W-1:0];
              want.overlaps = hit;
              want.whole = contained;
              want.partial = hit & ~contained;
              want.last = (t == scan_tiles - 1);
              verdicts_due = {verdicts_due, want};
            end
          end
          default: ;
        endcase
      end
      pending_o = verdicts_due.size();
    end
  end

endmodule

// ===== tb/sv/tb_box_range_overlap_query.sv =====
// Testbench top for the box range overlap query block: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_box_range_overlap_query;
  import bror_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED     = 2'd3;
  localparam logic [COORD_W-1:0]  COORD_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [COORD_W-1:0]  COORD_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int                  NUM_SEGS      = 12;
  localparam int                  SEG_ITEMS     = 27;
  localparam int                  SETTLE_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OPCODE_W-1:0]   opcode = OP_LOAD;
  logic [SLOT_W-1:0]     tile_slot = '0;
  logic [DSLOT_W-1:0]    dim_slot = '0;
  logic [COORD_W-1:0]    range_low = '0;
  logic [COORD_W-1:0]    range_high = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TILENUM_W-1:0]  tile_number;
  logic                  overlaps;
  logic                  whole;
  logic                  partial;
  logic                  last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TILES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  int                    send_idle = 15;
  int                    recv_idle = 87;
  logic [TILES_W-1:0]    tiles_now = '0;
  logic [DIMS_W-1:0]     dims_now = DIMS_RESET;
  bit                    box_loaded [NUM_TILES_DEF][MAX_DIMS_DEF];
  bit                    query_loaded [MAX_DIMS_DEF];

  box_range_overlap_query dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .tile_slot_i  (tile_slot),
    .dim_slot_i   (dim_slot),
    .range_low_i  (range_low),
    .range_high_i (range_high),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .tile_number_o(tile_number),
    .overlaps_o   (overlaps),
    .whole_o      (whole),
    .partial_o    (partial),
    .last_o       (last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  bror_overlap_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .opcode_i     (opcode),
    .tile_slot_i  (tile_slot),
    .dim_slot_i   (dim_slot),
    .range_low_i  (range_low),
    .range_high_i (range_high),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .tile_number_i(tile_number),
    .overlaps_i   (overlaps),
    .whole_i      (whole),
    .partial_i    (partial),
    .last_i       (last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin
    #10_000_000;
    $display("** box_range_overlap_query: FAILED **");
    $finish;
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    int near_zero;
    near_zero = int'($urandom_range(0, 40)) - 20;
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '1;
      3, 4: return {$urandom, $urandom};
      default: return {{32{near_zero[31]}}, near_zero};
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] tile,
                           input logic [DSLOT_W-1:0] dim, input logic [COORD_W-1:0] lo,
                           input logic [COORD_W-1:0] hi);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    tile_slot  <= tile;
    dim_slot   <= dim;
    range_low  <= lo;
    range_high <= hi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    case (op)
      OP_LOAD:  box_loaded[tile][dim] = 1'b1;
      OP_RANGE: query_loaded[dim] = 1'b1;
      default: ;
    endcase
  endtask

  // Hold the sender off until every expected result is out, then let the pipeline drain.
  task automatic settle(input int cycles);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic set_config(input logic [TILES_W-1:0] tiles, input logic [DIMS_W-1:0] dims);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TILES;
    cfg_data  <= CFG_DATA_W'(tiles);
    @(negedge clk);
    cfg_index <= CFG_DIMS;
    cfg_data  <= CFG_DATA_W'(dims);
    @(negedge clk);
    cfg_we    <= 1'b0;
    tiles_now = tiles;
    dims_now = dims;
  endtask

  initial begin
    int                  tile_plan [8];
    int                  dim_plan [8];
    int                  eff_tiles;
    int                  eff_dims;
    int                  sent;
    int                  pick;
    logic [COORD_W-1:0]  lo;
    logic [COORD_W-1:0]  hi;
    logic [COORD_W-1:0]  swap;
    logic [OPCODE_W-1:0] next_op;
    logic [SLOT_W-1:0]   next_tile;
    logic [DSLOT_W-1:0]  next_dim;

    tile_plan = '{4, 1, 16, 8, 31, 0, 17, 2};
    dim_plan = '{2, 1, 4, 3, 7, 3, 5, 0};
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part. With no tiles in use a query produces nothing.
    send_item(OP_QUERY, 0, 0, 0, 0);
    send_item(OP_LOAD, 0, 0, COORD_MIN, COORD_MAX);
    send_item(OP_LOAD, 0, 1, -5, 5);
    send_item(OP_LOAD, 1, 0, 10, 20);
    send_item(OP_LOAD, 1, 1, COORD_MAX, COORD_MIN);
    send_item(OP_LOAD, 2, 0, 10, -10);
    send_item(OP_LOAD, 2, 1, -1, -1);
    send_item(OP_RANGE, 0, 0, 0, 0);
    send_item(OP_RANGE, 0, 1, -10, 10);
    settle(SETTLE_CYCLES);
    set_config(3, 2);
    send_item(OP_QUERY, 0, 0, 0, 0);
    send_item(OP_RANGE, 0, 0, COORD_MIN, COORD_MAX);
    send_item(OP_RANGE, 0, 1, 5, 5);
    send_item(OP_QUERY, 0, 0, 0, 0);
    send_item(OP_RANGE, 0, 1, COORD_MAX, COORD_MIN);
    send_item(OP_QUERY, 0, 0, 0, 0);
    send_item(OP_UNUSED, '1, '1, '1, '1);
    settle(SETTLE_CYCLES);
    set_config(3, 0);
    send_item(OP_QUERY, 0, 0, 0, 0);
    settle(SETTLE_CYCLES);
    set_config(3, 1);
    send_item(OP_QUERY, 0, 0, 0, 0);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      send_idle = (seg < 4) ? 15 : (seg < 8) ? 87 : 0;
      recv_idle = (seg < 4) ? 87 : (seg < 8) ? 15 : 0;
      settle(SETTLE_CYCLES);
      if (seg < 8) set_config(TILES_W'(tile_plan[seg]), DIMS_W'(dim_plan[seg]));
      else set_config(TILES_W'($urandom_range(0, 31)), DIMS_W'($urandom_range(0, 7)));
      eff_tiles = (tiles_now > NUM_TILES_DEF) ? NUM_TILES_DEF : tiles_now;
      eff_dims = (dims_now > MAX_DIMS_DEF) ? MAX_DIMS_DEF : dims_now;
      sent = 0;
      while (sent < SEG_ITEMS) begin
        pick = $urandom_range(0, 99);
        lo = rand_coord();
        hi = rand_coord();
        if ($urandom_range(0, 3) != 0 && $signed(lo) > $signed(hi)) begin
          swap = lo;
          lo = hi;
          hi = swap;
        end
        next_tile = SLOT_W'($urandom_range(0, 15));
        next_dim = DSLOT_W'($urandom_range(0, 3));
        if (pick < 8) begin
          next_op = OP_UNUSED;
        end else if (pick < 45) begin
          next_op = OP_LOAD;
          if (eff_tiles > 0 && $urandom_range(0, 3) != 0)
            next_tile = SLOT_W'($urandom_range(0, eff_tiles - 1));
        end else if (pick < 60) begin
          next_op = OP_RANGE;
        end else begin
          // A query may only read entries that were written, so fill the lowest gap first.
          next_op = OP_QUERY;
          for (int d = MAX_DIMS_DEF - 1; d >= 0; d--) begin
            if (d < eff_dims && !query_loaded[d]) begin
              next_op = OP_RANGE;
              next_dim = DSLOT_W'(d);
            end
          end
          if (next_op == OP_QUERY) begin
            for (int t = NUM_TILES_DEF - 1; t >= 0; t--) begin
              for (int d = MAX_DIMS_DEF - 1; d >= 0; d--) begin
                if (t < eff_tiles && d < eff_dims && !box_loaded[t][d]) begin
                  next_op = OP_LOAD;
                  next_tile = SLOT_W'(t);
                  next_dim = DSLOT_W'(d);
                end
              end
            end
          end
        end
        send_item(next_op, next_tile, next_dim, lo, hi);
        if (next_op == OP_QUERY && $urandom_range(0, 19) == 0) settle(1);
        if (next_op != OP_UNUSED) sent++;
      end
    end

    settle(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("** box_range_overlap_query: PASSED **");
    end else begin
      $display("** box_range_overlap_query: FAILED **");
    end
    $finish;
  end

endmodule
